@@ hw/rtl/phsc_pkg.sv @@
// phsc_pkg: shared types, codes and constants for the pH setpoint controller.
// Holds the controller states, command/status structs and the quarter-wave builder.
// No dependencies.
package phsc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_DIV,
        ST_LOOK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic start;
        logic look;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

    localparam logic [1:0] MODE_FLAT = 2'd0;
    localparam logic [1:0] MODE_RAMP = 2'd1;
    localparam logic [1:0] MODE_SINE = 2'd2;
    localparam logic [1:0] MODE_HOLD = 2'd3;

    localparam int CFG_IW = 4;
    localparam logic [CFG_IW-1:0] REG_MODE       = 4'd0;
    localparam logic [CFG_IW-1:0] REG_BASE       = 4'd1;
    localparam logic [CFG_IW-1:0] REG_RAMP_BEGIN = 4'd2;
    localparam logic [CFG_IW-1:0] REG_RAMP_END   = 4'd3;
    localparam logic [CFG_IW-1:0] REG_RAMP_ORG   = 4'd4;
    localparam logic [CFG_IW-1:0] REG_PERIOD     = 4'd5;
    localparam logic [CFG_IW-1:0] REG_AMPL       = 4'd6;
    localparam logic [CFG_IW-1:0] REG_WAVE_ORG   = 4'd7;

    localparam logic [13:0] BASE_RESET = 14'd8100;
    localparam logic signed [17:0] TGT_MIN = -18'sd20000;
    localparam logic signed [17:0] TGT_MAX = 18'sd34000;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] SER_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210, 64'd272};

    // sin(x) in Q16 from x in Q30, Taylor series to nine terms
    function automatic logic [16:0] sine_q16(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] q;
        logic signed [63:0] sum;
        x2 = (x * x) >> 30;
        term = x;
        sum = signed'(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / SER_DIV[n-1];
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        q = (unsigned'(sum) + 64'd8192) >> 14;
        if (q > 64'd65536)
            q = 64'd65536;
        return q[16:0];
    endfunction

endpackage

@@ hw/rtl/ph_setpoint_solenoid_controller.sv @@
// Sequence: an accepted request passes the prep, start, divide, lookup and finish
// states; DVW is the dividend width of the bit-serial ramp/sine divider.
// Requests go one at a time: a new one is accepted only after the last one finishes.
// Reset: asynchronous, active low; config registers take their reset values,
// held target and sine cycle state clear, no result pending.
// Depends on phsc_pkg, phsc_ctrl, phsc_dp.
module ph_setpoint_solenoid_controller #(
    parameter int WINDOW_MS    = 10000,
    parameter int OPENING_MS   = 100,
    parameter int ON_TIME_MS   = 9000,
    parameter int SINE_ENTRIES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [phsc_pkg::CFG_IW-1:0] cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [13:0]                 measured_ph,
    input  logic [31:0]                 time_seconds,
    input  logic [31:0]                 time_millis,
    input  logic                        calibrating,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        solenoid_on,
    output logic signed [16:0]          current_target,
    output logic                        cycle_restarted
);

    phsc_pkg::cmd_t    cmd;
    phsc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    phsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    phsc_dp #(
        .WINDOW_MS    (WINDOW_MS),
        .OPENING_MS   (OPENING_MS),
        .ON_TIME_MS   (ON_TIME_MS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .measured_ph     (measured_ph),
        .time_seconds    (time_seconds),
        .time_millis     (time_millis),
        .calibrating     (calibrating),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .solenoid_on     (solenoid_on),
        .current_target  (current_target),
        .cycle_restarted (cycle_restarted)
    );

endmodule

@@ hw/rtl/phsc_div.sv @@
// phsc_div: restoring divider, one quotient bit per cycle.
// Standalone; used for the ramp/sine division.
module phsc_div #(
    parameter int DW = 46,
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder,
    output logic          done
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [VW:0]   rem_sh;
    logic [VW:0]   diff;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DW-1]};
        diff = rem_sh - {1'b0, dsr_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[VW])
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign remainder = rem_reg;
    assign done = !busy_reg;

endmodule

@@ hw/rtl/phsc_ctrl.sv @@
// phsc_ctrl: sequencer for one request through the datapath.
// Depends on phsc_pkg.
module phsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  phsc_pkg::status_t status,
    output phsc_pkg::cmd_t    cmd
);

    phsc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= phsc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            phsc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = phsc_pkg::ST_PREP;
                end
            end
            phsc_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = phsc_pkg::ST_START;
            end
            phsc_pkg::ST_START:
            begin
                cmd.start = 1'b1;
                state_next = phsc_pkg::ST_DIV;
            end
            phsc_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = phsc_pkg::ST_LOOK;
            end
            phsc_pkg::ST_LOOK:
            begin
                cmd.look = 1'b1;
                state_next = phsc_pkg::ST_FIN;
            end
            phsc_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.fin = 1'b1;
                    state_next = phsc_pkg::ST_IDLE;
                end
            end
            default:
                state_next = phsc_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/phsc_dp.sv @@
// phsc_dp: config registers, target datapath, window remainder and result register.
// Depends on phsc_pkg and phsc_div.
module phsc_dp #(
    parameter int WINDOW_MS    = 10000,
    parameter int OPENING_MS   = 100,
    parameter int ON_TIME_MS   = 9000,
    parameter int SINE_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  phsc_pkg::cmd_t                cmd,
    output phsc_pkg::status_t             status,
    input  logic                          cfg_we,
    input  logic [phsc_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic [13:0]                   measured_ph,
    input  logic [31:0]                   time_seconds,
    input  logic [31:0]                   time_millis,
    input  logic                          calibrating,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          solenoid_on,
    output logic signed [16:0]            current_target,
    output logic                          cycle_restarted
);

    localparam int PW  = $clog2(4 * SINE_ENTRIES);
    localparam int DVW = 32 + ((PW > 14) ? PW : 14);
    localparam int IW  = $clog2(SINE_ENTRIES + 1);
    localparam logic [PW-1:0] P_MAX = PW'(4 * SINE_ENTRIES - 1);
    localparam logic [PW-1:0] N1 = PW'(SINE_ENTRIES);
    localparam logic [PW-1:0] N2 = PW'(2 * SINE_ENTRIES);
    localparam logic [PW-1:0] N3 = PW'(3 * SINE_ENTRIES);
    localparam logic SOL_EN = (OPENING_MS < ON_TIME_MS);
    // reciprocal of the window length, 2^32 / WINDOW_MS
    localparam logic [22:0] WIN_RECIP = 23'(64'h1_0000_0000 / 64'(WINDOW_MS));

    // quarter-wave sine table, Q16
    logic [16:0] qtab [SINE_ENTRIES+1];
    for (genvar g = 0; g <= SINE_ENTRIES; g++)
    begin : g_tab
        localparam logic [63:0] XQ = (64'(g) * phsc_pkg::PI_Q30) / (2 * SINE_ENTRIES);
        assign qtab[g] = phsc_pkg::sine_q16(XQ);
    end

    logic [1:0]  mode_reg;
    logic [13:0] base_reg, origin_reg, ampl_reg;
    logic [31:0] rbeg_reg, rend_reg, period_reg, worg_reg;
    logic        loaded_reg;
    logic [31:0] cs_reg;
    logic signed [16:0] held_reg;

    logic [13:0] ph_reg;
    logic [31:0] t_reg;
    logic        cal_reg;
    logic [31:0] cs_eff_reg, new_cs_reg;
    logic        restart_reg, end_hit_reg, beg_hit_reg, neg_reg;
    logic [13:0] mag_reg;
    logic [31:0] tb_reg, span_reg;
    logic [DVW-1:0] dvd_reg;
    logic [31:0] dsr_reg;
    logic [16:0] s_reg;
    logic [1:0]  quad_reg;
    logic [13:0] rq_reg;
    logic [31:0] ms_reg;
    logic [22:0] qe_reg;
    logic [16:0] rw_reg;

    logic        ov_reg;
    logic        sol_reg, rst_out_reg;
    logic signed [16:0] tgt_reg;

    logic [DVW-1:0] main_quo;
    logic [31:0]    main_rem;
    logic           main_done;

    logic        cfg_known;
    logic [31:0] cs_eff;
    logic [31:0] new_cs;
    logic [31:0] elapsed;
    logic        sine_on;
    logic [PW-1:0] p;
    logic [1:0]  quad;
    logic [PW-1:0] kfull;
    logic [IW-1:0] kidx, tidx;
    logic [31:0] scl_full;
    logic signed [17:0] raw, sat;
    logic        fin_restart, fin_on;
    logic [54:0] qe_prod;
    logic [31:0] rw_full;
    logic [16:0] mod_rem;

    phsc_div #(.DW(DVW), .VW(32)) u_div_main (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start),
        .dividend  (dvd_reg),
        .divisor   (dsr_reg),
        .quotient  (main_quo),
        .remainder (main_rem),
        .done      (main_done)
    );

    // window phase: quotient estimate by reciprocal, low by at most one
    assign qe_prod = 55'(ms_reg) * 55'(WIN_RECIP);
    assign rw_full = ms_reg - 32'(qe_reg) * 32'(WINDOW_MS);
    assign mod_rem = (rw_reg >= 17'(WINDOW_MS)) ? (rw_reg - 17'(WINDOW_MS)) : rw_reg;

    assign status.div_done = main_done && (main_rem == main_rem);
    assign status.out_free = !ov_reg || out_ready;

    assign cfg_known = (cfg_index == phsc_pkg::REG_MODE)
        || (cfg_index == phsc_pkg::REG_BASE)
        || (cfg_index == phsc_pkg::REG_RAMP_BEGIN)
        || (cfg_index == phsc_pkg::REG_RAMP_END)
        || (cfg_index == phsc_pkg::REG_RAMP_ORG)
        || (cfg_index == phsc_pkg::REG_PERIOD)
        || (cfg_index == phsc_pkg::REG_AMPL)
        || (cfg_index == phsc_pkg::REG_WAVE_ORG);

    assign sine_on = (mode_reg == phsc_pkg::MODE_SINE) && (period_reg != 32'd0);
    assign cs_eff = loaded_reg ? cs_reg : worg_reg;
    assign new_cs = restart_reg ? t_reg : cs_eff_reg;
    assign elapsed = (t_reg >= new_cs) ? (t_reg - new_cs) : 32'd0;

    always_comb
    begin
        p = (main_quo > DVW'(P_MAX)) ? P_MAX : main_quo[PW-1:0];
        if (p >= N3)
            quad = 2'd3;
        else if (p >= N2)
            quad = 2'd2;
        else if (p >= N1)
            quad = 2'd1;
        else
            quad = 2'd0;
        case (quad)
            2'd0:    kfull = p;
            2'd1:    kfull = p - N1;
            2'd2:    kfull = p - N2;
            default: kfull = p - N3;
        endcase
        kidx = kfull[IW-1:0];
        tidx = quad[0] ? (IW'(SINE_ENTRIES) - kidx) : kidx;
    end

    always_comb
    begin
        scl_full = 32'(ampl_reg) * 32'(s_reg) + 32'd32768;
        case (mode_reg)
            phsc_pkg::MODE_FLAT:
                raw = signed'({4'b0, base_reg});
            phsc_pkg::MODE_RAMP:
            begin
                if (end_hit_reg)
                    raw = signed'({4'b0, base_reg});
                else if (beg_hit_reg)
                    raw = signed'({4'b0, origin_reg});
                else if (neg_reg)
                    raw = signed'({4'b0, origin_reg}) - signed'({4'b0, rq_reg});
                else
                    raw = signed'({4'b0, origin_reg}) + signed'({4'b0, rq_reg});
            end
            phsc_pkg::MODE_SINE:
            begin
                if (period_reg == 32'd0)
                    raw = signed'({4'b0, base_reg});
                else if (quad_reg[1])
                    raw = signed'({4'b0, base_reg}) - signed'({2'b0, scl_full[31:16]});
                else
                    raw = signed'({4'b0, base_reg}) + signed'({2'b0, scl_full[31:16]});
            end
            default:
                raw = {held_reg[16], held_reg};
        endcase
        if (raw < phsc_pkg::TGT_MIN)
            sat = phsc_pkg::TGT_MIN;
        else if (raw > phsc_pkg::TGT_MAX)
            sat = phsc_pkg::TGT_MAX;
        else
            sat = raw;
        fin_restart = sine_on && restart_reg;
        fin_on = SOL_EN && !cal_reg && (signed'({4'b0, ph_reg}) > sat)
            && (mod_rem < 17'(ON_TIME_MS));
    end

    // config registers and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= phsc_pkg::MODE_FLAT;
            base_reg <= phsc_pkg::BASE_RESET;
            rbeg_reg <= '0;
            rend_reg <= '0;
            origin_reg <= phsc_pkg::BASE_RESET;
            period_reg <= '0;
            ampl_reg <= '0;
            worg_reg <= '0;
            loaded_reg <= 1'b0;
            cs_reg <= '0;
            held_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    phsc_pkg::REG_MODE:       mode_reg <= cfg_data[1:0];
                    phsc_pkg::REG_BASE:       base_reg <= cfg_data[13:0];
                    phsc_pkg::REG_RAMP_BEGIN: rbeg_reg <= cfg_data;
                    phsc_pkg::REG_RAMP_END:   rend_reg <= cfg_data;
                    phsc_pkg::REG_RAMP_ORG:   origin_reg <= cfg_data[13:0];
                    phsc_pkg::REG_PERIOD:     period_reg <= cfg_data;
                    phsc_pkg::REG_AMPL:       ampl_reg <= cfg_data[13:0];
                    phsc_pkg::REG_WAVE_ORG:   worg_reg <= cfg_data;
                    default:                  mode_reg <= mode_reg;
                endcase
            end
            if (cfg_we && cfg_known)
                loaded_reg <= 1'b0;
            else if (cmd.fin && sine_on)
                loaded_reg <= 1'b1;
            if (cmd.fin && sine_on)
                cs_reg <= new_cs_reg;
            if (cmd.fin)
                held_reg <= sat[16:0];
            if (cmd.fin)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ph_reg <= measured_ph;
            t_reg <= time_seconds;
            cal_reg <= calibrating;
            ms_reg <= time_millis;
            cs_eff_reg <= cs_eff;
            restart_reg <= {1'b0, time_seconds} >= ({1'b0, cs_eff} + {1'b0, period_reg});
            end_hit_reg <= time_seconds >= rend_reg;
            beg_hit_reg <= time_seconds <= rbeg_reg;
            neg_reg <= base_reg < origin_reg;
            mag_reg <= (base_reg < origin_reg) ? (origin_reg - base_reg)
                                               : (base_reg - origin_reg);
            tb_reg <= time_seconds - rbeg_reg;
            span_reg <= rend_reg - rbeg_reg;
        end
        if (cmd.prep)
        begin
            new_cs_reg <= new_cs;
            qe_reg <= qe_prod[54:32];
            if (mode_reg == phsc_pkg::MODE_SINE)
            begin
                dvd_reg <= DVW'(elapsed) * DVW'(4 * SINE_ENTRIES);
                dsr_reg <= period_reg;
            end
            else
            begin
                dvd_reg <= DVW'(tb_reg) * DVW'(mag_reg);
                dsr_reg <= span_reg;
            end
        end
        if (cmd.start)
            rw_reg <= rw_full[16:0];
        if (cmd.look)
        begin
            s_reg <= qtab[tidx];
            quad_reg <= quad;
            rq_reg <= main_quo[13:0];
        end
        if (cmd.fin)
        begin
            sol_reg <= fin_on;
            tgt_reg <= sat[16:0];
            rst_out_reg <= fin_restart;
        end
    end

    assign out_valid = ov_reg;
    assign solenoid_on = sol_reg;
    assign current_target = tgt_reg;
    assign cycle_restarted = rst_out_reg;

`ifndef NO_ASSERTIONS
    a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_known) |=> !loaded_reg)
        else $error("sine cycle not reloaded after register write");
    a_restart_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin && fin_restart) |-> (mode_reg == phsc_pkg::MODE_SINE))
        else $error("cycle restart outside sine mode");
    a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> main_done)
        else $error("result taken before division finished");
`endif

endmodule
